// File: rtl/sa_pkg.sv
// ----------------------------------------------------------------------------
// sa_pkg
// Shared types and constants for the stable sample averager: status codes,
// configuration register indexes and reset values, and the control structs.
// ----------------------------------------------------------------------------
package sa_pkg;

    // result status codes
    localparam logic [2:0] ST_PENDING  = 3'd0;
    localparam logic [2:0] ST_POINT    = 3'd1;
    localparam logic [2:0] ST_TIMEOUT  = 3'd2;
    localparam logic [2:0] ST_UNSTABLE = 3'd3;
    localparam logic [2:0] ST_IDLE     = 3'd4;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W  = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPREAD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd2;

    // configuration reset values
    localparam logic [15:0] SETTLE_RESET  = 16'd200;
    localparam logic [15:0] SPREAD_RESET  = 16'd4;
    localparam logic [15:0] TIMEOUT_RESET = 16'd5000;

    // live configuration
    typedef struct packed {
        logic [15:0] settle_ticks;
        logic [15:0] spread_limit;
        logic [15:0] timeout_ticks;
    } sa_cfg_t;

    // per-word result control
    typedef struct packed {
        logic [2:0] status;
        logic [2:0] held;
    } sa_res_t;

endpackage

// File: rtl/stable_sample_averager.sv
// ----------------------------------------------------------------------------
// stable_sample_averager
// Windowed x/y averager with a spread check on both axes. A restart word
// opens a window with a deadline; polls feed samples into a batch that is
// either emitted as averages or dropped as unstable.
//
//   channel   direction  handshake                 payload
//   in        input      in_valid / in_stall       operation, tick, sensor_ready,
//                                                  snap_seq, pixel_x, pixel_y
//   out       output     out_valid / out_stall     status, avg_x, avg_y,
//                                                  samples_held
//   cfg       input      cfg_we                    cfg_index, cfg_data
//
// One word per cycle is accepted while in_stall is low; each word gives one result.
// Stage one is the window/batch update register, stage two the reciprocal
// divide and output register.
// rst_n clears the window to idle and loads the register defaults
// (settle 200, spread 4, timeout 5000).
// in_stall rises only when both stages hold words and out_stall is high.
// ----------------------------------------------------------------------------
module stable_sample_averager
    import sa_pkg::*;
#(
    parameter int SAMPLES = 5
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 operation,
    input  logic [31:0]          tick,
    input  logic                 sensor_ready,
    input  logic [15:0]          snap_seq,
    input  logic signed [15:0]   pixel_x,
    input  logic signed [15:0]   pixel_y,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [2:0]           status,
    output logic signed [15:0]   avg_x,
    output logic signed [15:0]   avg_y,
    output logic [2:0]           samples_held,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);

    localparam int SUM_W = 16 + $clog2(SAMPLES);

    sa_cfg_t                 cfg_reg;
    logic                    s1_valid;
    sa_res_t                 s1_res;
    logic signed [SUM_W-1:0] s1_sum_x, s1_sum_y;
    logic                    s2_move;
    logic                    s1_move;
    logic                    accept;
    logic                    take;

    // pipeline advance
    assign s2_move  = !out_valid || !out_stall;
    assign s1_move  = !s1_valid || s2_move;
    assign in_stall = !s1_move;
    assign accept   = in_valid && s1_move;
    assign take     = s1_valid && s2_move;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.settle_ticks  <= SETTLE_RESET;
            cfg_reg.spread_limit  <= SPREAD_RESET;
            cfg_reg.timeout_ticks <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SETTLE:  cfg_reg.settle_ticks  <= cfg_data;
                CFG_SPREAD:  cfg_reg.spread_limit  <= cfg_data;
                CFG_TIMEOUT: cfg_reg.timeout_ticks <= cfg_data;
                default:     ;
            endcase
        end
    end

    // window state and collector
    sa_core #(
        .SAMPLES (SAMPLES)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .accept       (accept),
        .take         (take),
        .operation    (operation),
        .tick         (tick),
        .sensor_ready (sensor_ready),
        .snap_seq     (snap_seq),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .s1_valid     (s1_valid),
        .s1_res       (s1_res),
        .s1_sum_x     (s1_sum_x),
        .s1_sum_y     (s1_sum_y)
    );

    // averaging and output register
    sa_div #(
        .SAMPLES (SAMPLES)
    ) u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (s2_move),
        .s1_valid     (s1_valid),
        .s1_res       (s1_res),
        .s1_sum_x     (s1_sum_x),
        .s1_sum_y     (s1_sum_y),
        .out_valid    (out_valid),
        .status       (status),
        .avg_x        (avg_x),
        .avg_y        (avg_y),
        .samples_held (samples_held)
    );

    // checks
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid && out_valid && out_stall)
        else $error("input stalled with room in the pipeline");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid && !take && !accept |=> s1_valid)
        else $error("stage one word dropped");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(samples_held))
        else $error("stalled output word changed");

endmodule

// File: rtl/sa_core.sv
// ----------------------------------------------------------------------------
// sa_core
// Window state and sample collector. Each accepted word updates the window,
// sums and bounds in one pass and lands in the stage-one result register.
// ----------------------------------------------------------------------------
module sa_core
    import sa_pkg::*;
#(
    parameter int SAMPLES = 5
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  sa_cfg_t                             cfg,
    input  logic                                accept,
    input  logic                                take,
    input  logic                                operation,
    input  logic [31:0]                         tick,
    input  logic                                sensor_ready,
    input  logic [15:0]                         snap_seq,
    input  logic signed [15:0]                  pixel_x,
    input  logic signed [15:0]                  pixel_y,
    output logic                                s1_valid,
    output sa_res_t                             s1_res,
    output logic signed [16+$clog2(SAMPLES)-1:0] s1_sum_x,
    output logic signed [16+$clog2(SAMPLES)-1:0] s1_sum_y
);

    localparam int SUM_W = 16 + $clog2(SAMPLES);
    localparam int CNT_W = $clog2(SAMPLES + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(SAMPLES);

    // window and batch state
    logic                     active_reg, active_next;
    logic                     unstable_reg, unstable_next;
    logic [31:0]              start_reg, start_next;
    logic [31:0]              deadline_reg, deadline_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [15:0]              prev_seq_reg, prev_seq_next;
    logic signed [SUM_W-1:0]  sum_x_reg, sum_x_next;
    logic signed [SUM_W-1:0]  sum_y_reg, sum_y_next;
    logic signed [15:0]       min_x_reg, min_x_next;
    logic signed [15:0]       max_x_reg, max_x_next;
    logic signed [15:0]       min_y_reg, min_y_next;
    logic signed [15:0]       max_y_reg, max_y_next;

    // stage-one result register
    logic                     s1_valid_reg, s1_valid_next;
    sa_res_t                  s1_res_reg, s1_res_next;
    logic signed [SUM_W-1:0]  s1_sum_x_reg, s1_sum_x_next;
    logic signed [SUM_W-1:0]  s1_sum_y_reg, s1_sum_y_next;

    // per-word helpers
    logic [31:0]              since_deadline;
    logic [31:0]              since_start;
    logic                     take_sample;
    logic [CNT_W-1:0]         count_inc;
    logic signed [SUM_W-1:0]  add_x, add_y;
    logic signed [15:0]       lo_x, hi_x, lo_y, hi_y;
    logic [16:0]              spread_x, spread_y;
    logic                     too_wide;
    logic [2:0]               status;

    assign since_deadline = tick - deadline_reg;
    assign since_start    = tick - start_reg;
    assign take_sample    = (since_start >= {16'd0, cfg.settle_ticks}) && sensor_ready
                            && !((count_reg != '0) && (snap_seq == prev_seq_reg));
    assign count_inc      = count_reg + CNT_W'(1);
    assign add_x          = {{(SUM_W-16){pixel_x[15]}}, pixel_x};
    assign add_y          = {{(SUM_W-16){pixel_y[15]}}, pixel_y};

    // bounds widened by the current sample, first sample seeds them
    assign lo_x = ((count_reg == '0) || (pixel_x < min_x_reg)) ? pixel_x : min_x_reg;
    assign hi_x = ((count_reg == '0) || (pixel_x > max_x_reg)) ? pixel_x : max_x_reg;
    assign lo_y = ((count_reg == '0) || (pixel_y < min_y_reg)) ? pixel_y : min_y_reg;
    assign hi_y = ((count_reg == '0) || (pixel_y > max_y_reg)) ? pixel_y : max_y_reg;

    // spread of the widened bounds
    assign spread_x = {hi_x[15], hi_x} - {lo_x[15], lo_x};
    assign spread_y = {hi_y[15], hi_y} - {lo_y[15], lo_y};
    assign too_wide = (spread_x > {1'b0, cfg.spread_limit})
                      || (spread_y > {1'b0, cfg.spread_limit});

    // next state for one word
    always_comb
    begin
        active_next   = active_reg;
        unstable_next = unstable_reg;
        start_next    = start_reg;
        deadline_next = deadline_reg;
        count_next    = count_reg;
        prev_seq_next = prev_seq_reg;
        sum_x_next    = sum_x_reg;
        sum_y_next    = sum_y_reg;
        min_x_next    = min_x_reg;
        max_x_next    = max_x_reg;
        min_y_next    = min_y_reg;
        max_y_next    = max_y_reg;
        status        = ST_PENDING;
        s1_sum_x_next = '0;
        s1_sum_y_next = '0;

        if (!operation)
        begin
            // restart the window
            start_next    = tick;
            deadline_next = tick + {16'd0, cfg.timeout_ticks};
            unstable_next = 1'b0;
            active_next   = 1'b1;
            count_next    = '0;
            prev_seq_next = '0;
            sum_x_next    = '0;
            sum_y_next    = '0;
            min_x_next    = '0;
            max_x_next    = '0;
            min_y_next    = '0;
            max_y_next    = '0;
        end
        else if (!active_reg)
        begin
            status = ST_IDLE;
        end
        else if (!since_deadline[31])
        begin
            // deadline reached
            status      = unstable_reg ? ST_UNSTABLE : ST_TIMEOUT;
            active_next = 1'b0;
        end
        else if (take_sample)
        begin
            prev_seq_next = snap_seq;
            min_x_next    = lo_x;
            max_x_next    = hi_x;
            min_y_next    = lo_y;
            max_y_next    = hi_y;
            sum_x_next    = sum_x_reg + add_x;
            sum_y_next    = sum_y_reg + add_y;
            count_next    = count_inc;

            // full batch: reject or emit
            if (count_inc >= CNT_FULL)
            begin
                if (too_wide)
                begin
                    unstable_next = 1'b1;
                    count_next    = '0;
                    prev_seq_next = '0;
                    sum_x_next    = '0;
                    sum_y_next    = '0;
                    min_x_next    = '0;
                    max_x_next    = '0;
                    min_y_next    = '0;
                    max_y_next    = '0;
                end
                else
                begin
                    status        = ST_POINT;
                    active_next   = 1'b0;
                    s1_sum_x_next = sum_x_next;
                    s1_sum_y_next = sum_y_next;
                end
            end
        end

        s1_res_next.status = status;
        s1_res_next.held   = 3'(count_next);
    end

    // stage-one occupancy
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (take)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // control and window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            unstable_reg <= 1'b0;
            start_reg    <= '0;
            deadline_reg <= '0;
            count_reg    <= '0;
            prev_seq_reg <= '0;
            sum_x_reg    <= '0;
            sum_y_reg    <= '0;
            min_x_reg    <= '0;
            max_x_reg    <= '0;
            min_y_reg    <= '0;
            max_y_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (accept)
            begin
                active_reg   <= active_next;
                unstable_reg <= unstable_next;
                start_reg    <= start_next;
                deadline_reg <= deadline_next;
                count_reg    <= count_next;
                prev_seq_reg <= prev_seq_next;
                sum_x_reg    <= sum_x_next;
                sum_y_reg    <= sum_y_next;
                min_x_reg    <= min_x_next;
                max_x_reg    <= max_x_next;
                min_y_reg    <= min_y_next;
                max_y_reg    <= max_y_next;
            end
        end
    end

    // stage-one payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_res_reg   <= s1_res_next;
            s1_sum_x_reg <= s1_sum_x_next;
            s1_sum_y_reg <= s1_sum_y_next;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_res   = s1_res_reg;
    assign s1_sum_x = s1_sum_x_reg;
    assign s1_sum_y = s1_sum_y_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("batch count above sample count");

    a_restart_opens: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !operation |=> active_reg && (count_reg == '0) && !unstable_reg)
        else $error("restart did not open a clean window");

    a_point_closes: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && (s1_res_reg.status == ST_POINT) |-> !active_reg)
        else $error("point ready while window still open");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        accept && operation && !active_reg |=> !active_reg && $stable(count_reg))
        else $error("poll while idle changed the batch");

endmodule

// File: rtl/sa_div.sv
// ----------------------------------------------------------------------------
// sa_div
// Output stage: divides the batch sums by the sample count with a constant
// reciprocal multiply, truncating toward zero, into the output register.
// ----------------------------------------------------------------------------
module sa_div
    import sa_pkg::*;
#(
    parameter int SAMPLES = 5
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                load,
    input  logic                                s1_valid,
    input  sa_res_t                             s1_res,
    input  logic signed [16+$clog2(SAMPLES)-1:0] s1_sum_x,
    input  logic signed [16+$clog2(SAMPLES)-1:0] s1_sum_y,
    output logic                                out_valid,
    output logic [2:0]                          status,
    output logic signed [15:0]                  avg_x,
    output logic signed [15:0]                  avg_y,
    output logic [2:0]                          samples_held
);

    localparam int SUM_W  = 16 + $clog2(SAMPLES);
    localparam int SHIFT  = SUM_W + $clog2(SAMPLES);
    localparam int M_W    = SUM_W + 1;
    localparam int PROD_W = SUM_W + M_W;
    localparam logic [M_W-1:0] RECIP =
        M_W'(((64'd1 << SHIFT) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));

    logic               valid_reg, valid_next;
    sa_res_t            res_reg;
    logic signed [15:0] avg_x_reg, avg_x_next;
    logic signed [15:0] avg_y_reg, avg_y_next;

    logic               neg_x, neg_y;
    logic [SUM_W-1:0]   mag_x, mag_y;
    logic [PROD_W-1:0]  prod_x, prod_y;
    logic [15:0]        quo_x, quo_y;

    // magnitude, reciprocal multiply, sign restore
    assign neg_x  = s1_sum_x[SUM_W-1];
    assign neg_y  = s1_sum_y[SUM_W-1];
    assign mag_x  = neg_x ? (~s1_sum_x + SUM_W'(1)) : s1_sum_x;
    assign mag_y  = neg_y ? (~s1_sum_y + SUM_W'(1)) : s1_sum_y;
    assign prod_x = PROD_W'(mag_x) * PROD_W'(RECIP);
    assign prod_y = PROD_W'(mag_y) * PROD_W'(RECIP);
    assign quo_x  = prod_x[SHIFT +: 16];
    assign quo_y  = prod_y[SHIFT +: 16];
    assign avg_x_next = neg_x ? (~quo_x + 16'd1) : quo_x;
    assign avg_y_next = neg_y ? (~quo_y + 16'd1) : quo_y;

    assign valid_next = load ? s1_valid : valid_reg;

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg   <= s1_res;
            avg_x_reg <= avg_x_next;
            avg_y_reg <= avg_y_next;
        end
    end

    assign out_valid    = valid_reg;
    assign status       = res_reg.status;
    assign avg_x        = avg_x_reg;
    assign avg_y        = avg_y_reg;
    assign samples_held = res_reg.held;

    // checks
    a_avg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && (res_reg.status != ST_POINT) |-> (avg_x_reg == '0) && (avg_y_reg == '0))
        else $error("average nonzero without point ready");

    a_load_follows: assert property (@(posedge clk) disable iff (!rst_n)
        load && s1_valid |=> valid_reg)
        else $error("output word lost on load");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (res_reg.status <= ST_IDLE))
        else $error("status code out of range");

endmodule

// File: tb/sv/tb_stable_sample_averager.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stable_sample_averager
// Self-checking bench for the windowed x/y averager. A short table of directed
// words covers idle polls, settle and ready filtering, repeated sequences,
// extreme pixels, deadline wrap, rejected batches and truncation. Random
// restart/poll sequences follow under several register settings. Every result word is
// compared field by field with a cycle-free window model or a typed-in expectation.
// ----------------------------------------------------------------------------
module tb_stable_sample_averager;
    import sa_pkg::*;

    localparam int SAMPLES     = 5;
    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASE_WORDS = 250;

    // operation codes of an input word
    localparam logic OP_RESTART = 1'b0;
    localparam logic OP_POLL    = 1'b1;

    typedef struct packed {
        logic               op;
        logic [31:0]        tick;
        logic               ready;
        logic [15:0]        seq;
        logic signed [15:0] px;
        logic signed [15:0] py;
    } sensor_word_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic [2:0]         held;
    } avg_result_t;

    typedef struct {
        sensor_word_t w;
        bit           chk;
        avg_result_t  res;
    } dir_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic                 operation;
    logic [31:0]          tick;
    logic                 sensor_ready;
    logic [15:0]          snap_seq;
    logic signed [15:0]   pixel_x;
    logic signed [15:0]   pixel_y;
    logic                 out_valid;
    logic                 out_stall;
    logic [2:0]           status;
    logic signed [15:0]   avg_x;
    logic signed [15:0]   avg_y;
    logic [2:0]           samples_held;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0]          cfg_data;

    // typed-in expectation that travels with the current word
    bit                   fixed_chk;
    avg_result_t          fixed_res;

    bit                   idle_on;
    int                   err_count = 0;
    int                   cycle_cnt = 0;
    avg_result_t          pending_results[$];
    dir_row_t             dir_rows[$];

    // register copies
    logic [15:0]          settle_cfg  = SETTLE_RESET;
    logic [15:0]          spread_cfg  = SPREAD_RESET;
    logic [15:0]          timeout_cfg = TIMEOUT_RESET;

    // window and batch copies
    logic                 active       = 1'b0;
    logic                 unstable     = 1'b0;
    logic [31:0]          win_start    = '0;
    logic [31:0]          win_deadline = '0;
    logic [15:0]          seq_mark     = '0;
    int                   held_cnt     = 0;
    int                   sum_x        = 0;
    int                   sum_y        = 0;
    int                   min_x        = 0;
    int                   max_x        = 0;
    int                   min_y        = 0;
    int                   max_y        = 0;

    stable_sample_averager #(
        .SAMPLES(SAMPLES)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .tick         (tick),
        .sensor_ready (sensor_ready),
        .snap_seq     (snap_seq),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .avg_x        (avg_x),
        .avg_y        (avg_y),
        .samples_held (samples_held),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic void reset_batch();
        held_cnt = 0;
        seq_mark = '0;
        sum_x    = 0;
        sum_y    = 0;
        min_x    = 0;
        max_x    = 0;
        min_y    = 0;
        max_y    = 0;
    endfunction

    // window/batch update for one word, gives the result word it causes
    task automatic advance_window(input sensor_word_t w, output avg_result_t r);
        logic [31:0] late;
        logic [31:0] elapsed;
        int          px;
        int          py;
        r       = '{ST_PENDING, 16'sd0, 16'sd0, 3'd0};
        late    = w.tick - win_deadline;
        elapsed = w.tick - win_start;
        px      = int'(w.px);
        py      = int'(w.py);
        if (w.op == OP_RESTART)
        begin
            win_start    = w.tick;
            win_deadline = w.tick + {16'd0, timeout_cfg};
            unstable     = 1'b0;
            active       = 1'b1;
            reset_batch();
        end
        else if (!active)
        begin
            r.status = ST_IDLE;
        end
        else if (!late[31])
        begin
            // deadline reached, batch is kept
            r.status = unstable ? ST_UNSTABLE : ST_TIMEOUT;
            active   = 1'b0;
        end
        else if (elapsed >= {16'd0, settle_cfg} && w.ready &&
                 !(held_cnt != 0 && w.seq == seq_mark))
        begin
            seq_mark = w.seq;
            if (held_cnt == 0)
            begin
                min_x = px;
                max_x = px;
                min_y = py;
                max_y = py;
            end
            else
            begin
                if (px < min_x) min_x = px;
                if (px > max_x) max_x = px;
                if (py < min_y) min_y = py;
                if (py > max_y) max_y = py;
            end
            sum_x    += px;
            sum_y    += py;
            held_cnt += 1;
            if (held_cnt >= SAMPLES)
            begin
                if ((max_x - min_x) > int'(spread_cfg) || (max_y - min_y) > int'(spread_cfg))
                begin
                    unstable = 1'b1;
                    reset_batch();
                end
                else
                begin
                    r.ax     = 16'(sum_x / SAMPLES);
                    r.ay     = 16'(sum_y / SAMPLES);
                    r.status = ST_POINT;
                    active   = 1'b0;
                end
            end
        end
        r.held = 3'(held_cnt);
    endtask

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= 10)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // predict on accepted words, check accepted results
    always @(posedge clk)
    begin : scoreboard
        avg_result_t want;
        avg_result_t got;
        sensor_word_t w;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SETTLE:  settle_cfg  = cfg_data;
                    CFG_SPREAD:  spread_cfg  = cfg_data;
                    CFG_TIMEOUT: timeout_cfg = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                w = '{operation, tick, sensor_ready, snap_seq, pixel_x, pixel_y};
                advance_window(w, want);
                if (fixed_chk)
                    want = fixed_res;
                pending_results.push_back(want);
            end
            if (out_valid && !out_stall)
            begin
                got = '{status, avg_x, avg_y, samples_held};
                if (pending_results.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected word status %0d avg %0d,%0d held %0d",
                                              got.status, got.ax, got.ay, got.held));
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status || got.ax !== want.ax ||
                        got.ay !== want.ay || got.held !== want.held)
                        report_mismatch($sformatf(
                            "exp status %0d x %0d y %0d held %0d, got %0d x %0d y %0d held %0d",
                            want.status, want.ax, want.ay, want.held,
                            got.status, got.ax, got.ay, got.held));
                end
            end
        end
    end

    // receiver stall bursts
    initial
    begin : stall_gen
        int n;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 10);
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog
    initial
    begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("FAIL stable_sample_averager");
        $finish;
    end

    // drive one word from a falling edge, return at the falling edge after acceptance
    task automatic send_word(input sensor_word_t w, input bit chk, input avg_result_t fr);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 10);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        operation    <= w.op;
        tick         <= w.tick;
        sensor_ready <= w.ready;
        snap_seq     <= w.seq;
        pixel_x      <= w.px;
        pixel_y      <= w.py;
        fixed_chk    <= chk;
        fixed_res    <= fr;
        in_valid     <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    // hold off the sender until every result word is back
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic write_config(input logic [15:0] settle_v, input logic [15:0] spread_v,
                                input logic [15:0] timeout_v);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SETTLE;
        cfg_data  <= settle_v;
        @(negedge clk);
        cfg_index <= CFG_SPREAD;
        cfg_data  <= spread_v;
        @(negedge clk);
        cfg_index <= CFG_TIMEOUT;
        cfg_data  <= timeout_v;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic void add_row(input logic op, input logic [31:0] t, input logic rdy,
                                    input logic [15:0] sq, input int px, input int py,
                                    input bit chk, input logic [2:0] st, input int ax,
                                    input int ay, input int held);
        dir_row_t row;
        row.w   = '{op, t, rdy, sq, 16'(px), 16'(py)};
        row.chk = chk;
        row.res = '{st, 16'(ax), 16'(ay), 3'(held)};
        dir_rows.push_back(row);
    endfunction

    // restart/poll sequences with random content, mixed with noise words
    task automatic run_random(input int budget);
        sensor_word_t       w;
        avg_result_t        none;
        logic [31:0]        now;
        logic [15:0]        seq_n;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        int                 jx;
        int                 jy;
        int                 polls;
        int                 sent;
        bit                 paused;
        none   = '0;
        sent   = 0;
        paused = 1'b0;
        while (sent < budget)
        begin
            if (!paused && sent >= budget / 2)
            begin
                paused = 1'b1;
                drain_results();
            end
            if ($urandom_range(0, 6) == 0)
            begin
                // noise word
                w = '{1'($urandom), $urandom, 1'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom)};
                send_word(w, 1'b0, none);
                sent++;
            end
            else
            begin
                now = $urandom;
                w   = '{OP_RESTART, now, 1'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom)};
                send_word(w, 1'b0, none);
                sent++;
                seq_n = 16'($urandom);
                cx    = 16'($urandom);
                cy    = 16'($urandom);
                jx    = int'(spread_cfg) + $urandom_range(0, 2);
                jy    = int'(spread_cfg) + $urandom_range(0, 2);
                polls = $urandom_range(3, 12);
                for (int k = 0; k < polls; k++)
                begin
                    if (k == 0)
                        now += ($urandom_range(0, 4) == 0) ? $urandom_range(0, int'(settle_cfg))
                                                           : settle_cfg + $urandom_range(0, 2);
                    else if ($urandom_range(0, 29) == 0)
                        now += timeout_cfg;
                    else
                        now += $urandom_range(0, 3);
                    if ($urandom_range(0, 9) != 0)
                        seq_n++;
                    w.op    = OP_POLL;
                    w.tick  = now;
                    w.ready = ($urandom_range(0, 9) != 0);
                    w.seq   = seq_n;
                    w.px    = cx + 16'($urandom_range(0, jx));
                    w.py    = cy + 16'($urandom_range(0, jy));
                    send_word(w, 1'b0, none);
                    sent++;
                end
            end
        end
    endtask

    // main sequence
    initial
    begin : stimulus
        rst_n        = 1'b0;
        idle_on      = 1'b0;
        in_valid     = 1'b0;
        operation    = OP_RESTART;
        tick         = '0;
        sensor_ready = 1'b0;
        snap_seq     = '0;
        pixel_x      = '0;
        pixel_y      = '0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_SETTLE;
        cfg_data     = '0;
        fixed_chk    = 1'b0;
        fixed_res    = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        idle_on = 1'b1;

        // directed words under the reset settings
        // poll while idle, then a window with settle, not-ready and repeat filtering
        add_row(OP_POLL,    32'd0,    1'b1, 16'd0, 0, 0,           1, ST_IDLE,    0, 0, 0);
        add_row(OP_RESTART, 32'd1000, 1'b0, 16'd0, 0, 0,           1, ST_PENDING, 0, 0, 0);
        add_row(OP_POLL,    32'd1199, 1'b1, 16'd1, 5, 5,           1, ST_PENDING, 0, 0, 0);
        add_row(OP_POLL,    32'd1200, 1'b0, 16'd1, 5, 5,           1, ST_PENDING, 0, 0, 0);
        add_row(OP_POLL,    32'd1200, 1'b1, 16'd1, 32767, -32768,  1, ST_PENDING, 0, 0, 1);
        add_row(OP_POLL,    32'd1201, 1'b1, 16'd1, 32767, -32768,  1, ST_PENDING, 0, 0, 1);
        add_row(OP_POLL,    32'd1202, 1'b1, 16'd2, 32767, -32768,  1, ST_PENDING, 0, 0, 2);
        add_row(OP_POLL,    32'd1203, 1'b1, 16'd3, 32767, -32768,  1, ST_PENDING, 0, 0, 3);
        add_row(OP_POLL,    32'd1204, 1'b1, 16'd4, 32767, -32768,  1, ST_PENDING, 0, 0, 4);
        add_row(OP_POLL,    32'd1205, 1'b1, 16'd5, 32767, -32768,
                1, ST_POINT, 32767, -32768, 5);
        add_row(OP_POLL,    32'd1206, 1'b1, 16'd6, 0, 0,           1, ST_IDLE,    0, 0, 5);
        // window across the tick wrap, x spread too wide, then unstable timeout
        add_row(OP_RESTART, 32'hFFFF_FF00, 1'b1, 16'd0, 0, 0,      1, ST_PENDING, 0, 0, 0);
        add_row(OP_POLL,    32'hFFFF_FFC8, 1'b1, 16'hFFFF, -3, 2,  0, ST_PENDING, 0, 0, 0);
        add_row(OP_POLL,    32'h0000_0010, 1'b1, 16'd0, 4, 2,      0, ST_PENDING, 0, 0, 0);
        add_row(OP_POLL,    32'h0000_0011, 1'b1, 16'd1, 0, -1,     0, ST_PENDING, 0, 0, 0);
        add_row(OP_POLL,    32'h0000_0012, 1'b1, 16'd2, 0, 0,      0, ST_PENDING, 0, 0, 0);
        add_row(OP_POLL,    32'h0000_0013, 1'b1, 16'd3, 1, 1,      1, ST_PENDING, 0, 0, 0);
        add_row(OP_POLL,    32'h0000_1288, 1'b1, 16'd4, 1, 1,      1, ST_UNSTABLE, 0, 0, 0);
        // plain timeout at the exact deadline
        add_row(OP_RESTART, 32'd0,    1'b1, 16'd0, 0, 0,           1, ST_PENDING, 0, 0, 0);
        add_row(OP_POLL,    32'd5000, 1'b1, 16'd1, 0, 0,           1, ST_TIMEOUT, 0, 0, 0);
        // negative sums truncate toward zero
        add_row(OP_RESTART, 32'h7FFF_FFF0, 1'b0, 16'd0, 0, 0,      1, ST_PENDING, 0, 0, 0);
        add_row(OP_POLL,    32'h8000_00C0, 1'b1, 16'h8000, -1, 1,  0, ST_PENDING, 0, 0, 0);
        add_row(OP_POLL,    32'h8000_00C1, 1'b1, 16'h8001, -2, 2,  0, ST_PENDING, 0, 0, 0);
        add_row(OP_POLL,    32'h8000_00C2, 1'b1, 16'h8002, -1, 3,  0, ST_PENDING, 0, 0, 0);
        add_row(OP_POLL,    32'h8000_00C3, 1'b1, 16'h8003, -2, 1,  0, ST_PENDING, 0, 0, 0);
        add_row(OP_POLL,    32'h8000_00C4, 1'b1, 16'h8004, -1, 1,  0, ST_PENDING, 0, 0, 0);
        foreach (dir_rows[i])
            send_word(dir_rows[i].w, dir_rows[i].chk, dir_rows[i].res);
        drain_results();

        // random phases under several register settings
        for (int p = 0; p < 6; p++)
        begin
            idle_on = (p != 2) && (p != 5);
            case (p)
                1: write_config(16'd0, 16'd0, 16'hFFFF);
                2: write_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
                3: write_config(16'd3, 16'hFFFF, 16'd0);
                4: write_config(16'($urandom), 16'($urandom), 16'($urandom));
                5: write_config(16'($urandom_range(0, 300)), 16'($urandom_range(0, 12)),
                                16'($urandom_range(50, 3000)));
                default: ;
            endcase
            run_random(PHASE_WORDS);
            drain_results();
        end

        repeat (10) @(negedge clk);
        if (err_count == 0)
            $display("PASS stable_sample_averager");
        else
            $display("FAIL stable_sample_averager");
        $finish;
    end

endmodule
